// ----- rtl/core/quaternion_to_rotation_matrix_assert.svh -----
// Assertion macros for the quaternion to rotation matrix block.
// Used by the port checker; needs clk and arst_n in scope.
`ifndef QUATERNION_TO_ROTATION_MATRIX_ASSERT_SVH
`define QUATERNION_TO_ROTATION_MATRIX_ASSERT_SVH

// same-cycle implication
`define Q2R_ASSERT_NOW(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
		else $error("q2r assertion failed (same cycle)");

// next-cycle implication
`define Q2R_ASSERT_NEXT(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
		else $error("q2r assertion failed (next cycle)");

`endif

// ----- rtl/core/q2r_pkg.sv -----
// Shared types, widths and the restoring divide step for the q2r pipeline.
// No dependencies.
`timescale 1ns / 1ps
package q2r_pkg;
	localparam int RW = 48;   // remainder width
	localparam int DW = 34;   // divisor width (2*M)
	localparam int QW = 15;   // quotient width
	localparam int NL = 9;    // matrix elements
	localparam int AW = 33;   // numerator magnitude width
	localparam logic [QW-1:0] QONE = QW'(16384);
	localparam int DIAG0 = 0;
	localparam int DIAG1 = 4;
	localparam int DIAG2 = 8;

	typedef struct packed {
		logic          neg;
		logic [RW-1:0] rem;
		logic [QW-1:0] quo;
	} lane_t;

	typedef struct packed {
		lane_t [NL-1:0] lane;
		logic [DW-1:0]  den;
		logic           zero;
	} div_word_t;

	function automatic div_word_t div_step(input div_word_t w, input int shift);
		div_word_t     r;
		logic [RW-1:0] dsh;
		r = w;
		dsh = RW'(w.den) << shift;
		for (int i = 0; i < NL; i++) begin
			if (w.lane[i].rem >= dsh) begin
				r.lane[i].rem = w.lane[i].rem - dsh;
				r.lane[i].quo = {w.lane[i].quo[QW-2:0], 1'b1};
			end else begin
				r.lane[i].quo = {w.lane[i].quo[QW-2:0], 1'b0};
			end
		end
		return r;
	endfunction
endpackage

// ----- rtl/core/q2r_front.sv -----
// Front end: products, numerators and magnitude, then divider operand setup.
// Three pipeline stages; uses q2r_pkg.
`timescale 1ns / 1ps
module q2r_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [15:0]      q_real,
	input  logic signed [15:0]      q_x,
	input  logic signed [15:0]      q_y,
	input  logic signed [15:0]      q_z,
	output logic                    dn_valid,
	input  logic                    dn_ready,
	output q2r_pkg::div_word_t      dn_word
);
	import q2r_pkg::*;

	logic v_s1, v_s2, v_s3;
	logic en1, en2, en3;
	logic signed [31:0] rr_s1, xx_s1, yy_s1, zz_s1, xy_s1, zr_s1, xz_s1, yr_s1, yz_s1, xr_s1;
	logic signed [33:0] num_s2 [NL];
	logic [AW-1:0]      mag_s2;
	div_word_t          w_s3;
	div_word_t          w_nxt;
	logic signed [33:0] nm;
	logic [AW-1:0]      a;

	assign en3 = !v_s3 || dn_ready;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ready = en1;
	assign dn_valid = v_s3;
	assign dn_word = w_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			rr_s1 <= q_real * q_real;
			xx_s1 <= q_x * q_x;
			yy_s1 <= q_y * q_y;
			zz_s1 <= q_z * q_z;
			xy_s1 <= q_x * q_y;
			zr_s1 <= q_z * q_real;
			xz_s1 <= q_x * q_z;
			yr_s1 <= q_y * q_real;
			yz_s1 <= q_y * q_z;
			xr_s1 <= q_x * q_real;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			num_s2[0] <= 34'(rr_s1) + 34'(xx_s1) - 34'(yy_s1) - 34'(zz_s1);
			num_s2[1] <= (34'(xy_s1) - 34'(zr_s1)) <<< 1;
			num_s2[2] <= (34'(xz_s1) + 34'(yr_s1)) <<< 1;
			num_s2[3] <= (34'(xy_s1) + 34'(zr_s1)) <<< 1;
			num_s2[4] <= 34'(rr_s1) - 34'(xx_s1) + 34'(yy_s1) - 34'(zz_s1);
			num_s2[5] <= (34'(yz_s1) - 34'(xr_s1)) <<< 1;
			num_s2[6] <= (34'(xz_s1) - 34'(yr_s1)) <<< 1;
			num_s2[7] <= (34'(yz_s1) + 34'(xr_s1)) <<< 1;
			num_s2[8] <= 34'(rr_s1) - 34'(xx_s1) - 34'(yy_s1) + 34'(zz_s1);
			mag_s2 <= AW'($unsigned(rr_s1)) + AW'($unsigned(xx_s1))
				+ AW'($unsigned(yy_s1)) + AW'($unsigned(zz_s1));
		end
	end

	// remainder starts at a*2^15 + M, divisor 2*M: rounds to nearest, ties away
	always_comb begin
		w_nxt = '0;
		nm = '0;
		a = '0;
		w_nxt.den = {mag_s2, 1'b0};
		w_nxt.zero = (mag_s2 == '0);
		for (int i = 0; i < NL; i++) begin
			nm = num_s2[i];
			a = nm[33] ? AW'(-nm) : AW'(nm);
			w_nxt.lane[i].neg = nm[33];
			w_nxt.lane[i].rem = {a, 15'b0} + RW'(mag_s2);
			w_nxt.lane[i].quo = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en3) w_s3 <= w_nxt;
	end
endmodule

// ----- rtl/core/q2r_divider.sv -----
// Pipelined restoring divider: one quotient bit per stage, nine lanes sharing a divisor.
// Uses q2r_pkg.
`timescale 1ns / 1ps
module q2r_divider (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                up_valid,
	output logic                up_ready,
	input  q2r_pkg::div_word_t  up_word,
	output logic                dn_valid,
	input  logic                dn_ready,
	output q2r_pkg::div_word_t  dn_word
);
	import q2r_pkg::*;

	logic      v_s [QW];
	logic      en  [QW];
	div_word_t w_s [QW];

	assign up_ready = en[0];
	assign dn_valid = v_s[QW-1];
	assign dn_word = w_s[QW-1];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		div_word_t src;
		logic      src_v;
		if (k == 0) begin : g_first
			assign src = up_word;
			assign src_v = up_valid;
		end else begin : g_mid
			assign src = w_s[k-1];
			assign src_v = v_s[k-1];
		end
		if (k == QW-1) begin : g_last
			assign en[k] = !v_s[k] || dn_ready;
		end else begin : g_inner
			assign en[k] = !v_s[k] || en[k+1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en[k]) begin
				v_s[k] <= src_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en[k]) w_s[k] <= div_step(src, QW - 1 - k);
		end
	end
endmodule

// ----- rtl/core/quaternion_to_rotation_matrix.sv -----
// Channel  | signals                      | direction
// q        | q_valid q_stall q_real..q_z  | in
// m        | m_valid m_stall m_xx..m_zz,  | out
//          | zero_quaternion              |
// Pipeline: 3 front stages, 15 divider stages (one quotient bit each), then the output register.
// One word per cycle unless stalled; every stage has its own valid and advances when the next is free.
// A stalled result holds in the output register while upstream stages keep filling.
// arst_n clears all valid bits; data registers are not reset.
// Top level; uses q2r_pkg, q2r_front, q2r_divider.
`timescale 1ns / 1ps
module quaternion_to_rotation_matrix (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	output logic               q_stall,
	input  logic signed [15:0] q_real,
	input  logic signed [15:0] q_x,
	input  logic signed [15:0] q_y,
	input  logic signed [15:0] q_z,
	output logic               m_valid,
	input  logic               m_stall,
	output logic signed [15:0] m_xx,
	output logic signed [15:0] m_xy,
	output logic signed [15:0] m_xz,
	output logic signed [15:0] m_yx,
	output logic signed [15:0] m_yy,
	output logic signed [15:0] m_yz,
	output logic signed [15:0] m_zx,
	output logic signed [15:0] m_zy,
	output logic signed [15:0] m_zz,
	output logic               zero_quaternion
);
	import q2r_pkg::*;

	logic               f_ready, f_valid, d_ready, d_valid, en_out;
	div_word_t          f_word, d_word;
	logic signed [15:0] res [NL];
	logic signed [15:0] m_q [NL];
	logic               m_valid_q, zero_q;
	logic [QW-1:0]      qc;

	q2r_front u_front (
		.clk, .arst_n,
		.in_valid(q_valid), .in_ready(f_ready),
		.q_real, .q_x, .q_y, .q_z,
		.dn_valid(f_valid), .dn_ready(d_ready), .dn_word(f_word)
	);

	q2r_divider u_div (
		.clk, .arst_n,
		.up_valid(f_valid), .up_ready(d_ready), .up_word(f_word),
		.dn_valid(d_valid), .dn_ready(en_out), .dn_word(d_word)
	);

	assign q_stall = !f_ready;
	assign en_out = !m_valid_q || !m_stall;

	always_comb begin
		qc = '0;
		for (int i = 0; i < NL; i++) begin
			qc = (d_word.lane[i].quo > QONE) ? QONE : d_word.lane[i].quo;
			if (d_word.zero) begin
				res[i] = (i == DIAG0 || i == DIAG1 || i == DIAG2) ? 16'(QONE) : '0;
			end else begin
				res[i] = d_word.lane[i].neg ? -16'(qc) : 16'(qc);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (en_out) begin
			m_valid_q <= d_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			m_q <= res;
			zero_q <= d_word.zero;
		end
	end

	assign m_valid = m_valid_q;
	assign m_xx = m_q[0];
	assign m_xy = m_q[1];
	assign m_xz = m_q[2];
	assign m_yx = m_q[3];
	assign m_yy = m_q[4];
	assign m_yz = m_q[5];
	assign m_zx = m_q[6];
	assign m_zy = m_q[7];
	assign m_zz = m_q[8];
	assign zero_quaternion = zero_q;
endmodule

// ----- rtl/core/q2r_checker.sv -----
// Port-level checker for quaternion_to_rotation_matrix, bound to the top level.
// Uses quaternion_to_rotation_matrix_assert.svh.
`timescale 1ns / 1ps
module q2r_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               m_valid,
	input logic               m_stall,
	input logic signed [15:0] m_xx,
	input logic signed [15:0] m_xy,
	input logic signed [15:0] m_xz,
	input logic signed [15:0] m_yy,
	input logic signed [15:0] m_zz,
	input logic               zero_quaternion
);
`include "quaternion_to_rotation_matrix_assert.svh"

	`Q2R_ASSERT_NOW(a_zero_identity, m_valid && zero_quaternion, m_xx == 16'sd16384 && m_yy == 16'sd16384 && m_zz == 16'sd16384 && m_xy == 16'sd0 && m_xz == 16'sd0)
	`Q2R_ASSERT_NOW(a_range, m_valid, m_xx <= 16'sd16384 && m_xx >= -16'sd16384 && m_xy <= 16'sd16384 && m_xy >= -16'sd16384 && m_zz <= 16'sd16384 && m_zz >= -16'sd16384)
	`Q2R_ASSERT_NEXT(a_hold, m_valid && m_stall, m_valid && $stable(m_xx) && $stable(zero_quaternion))
endmodule

bind quaternion_to_rotation_matrix q2r_checker u_q2r_checker (
	.clk, .arst_n, .m_valid, .m_stall, .m_xx, .m_xy, .m_xz, .m_yy, .m_zz,
	.zero_quaternion
);
